@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/stt_pkg.sv @@
package stt_pkg;

  localparam int POSITION_BITS = 16;
  localparam int LINE_BITS     = 16;

  localparam int OUT_W = 16;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  localparam int SLOTS       = 3;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    K_EOF          = 5'd0,
    K_IDENT        = 5'd1,
    K_NUMBER       = 5'd2,
    K_STRING       = 5'd3,
    K_COMMENT      = 5'd4,
    K_LPAREN       = 5'd5,
    K_RPAREN       = 5'd6,
    K_LBRACE       = 5'd7,
    K_RBRACE       = 5'd8,
    K_LBRACKET     = 5'd9,
    K_RBRACKET     = 5'd10,
    K_COMMA        = 5'd11,
    K_DOT          = 5'd12,
    K_COLON        = 5'd13,
    K_COLON_EQUALS = 5'd14,
    K_DOUBLE_COLON = 5'd15,
    K_EQUALS       = 5'd16,
    K_DOUBLE_ARROW = 5'd17,
    K_ARROW        = 5'd18,
    K_ERROR        = 5'd19
  } tok_kind_e;

  typedef enum logic [1:0] {
    E_NONE       = 2'd0,
    E_UNTERM_STR = 2'd1,
    E_UNEXPECTED = 2'd2
  } err_e;

  typedef struct packed {
    err_e             err;
    logic [OUT_W-1:0] line;
    logic [OUT_W-1:0] len;
    logic [OUT_W-1:0] start;
    tok_kind_e        kind;
  } token_t;

  // close slots first, rescan slot last
  typedef struct packed {
    logic   [SLOTS-1:0] vld;
    token_t [SLOTS-1:0] tok;
  } bundle_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  function automatic logic [OUT_W-1:0] sat_pos(input logic [POSITION_BITS:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'(OUT_MAX)) ? OUT_MAX : w[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_line(input logic [LINE_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'(OUT_MAX)) ? OUT_MAX : w[OUT_W-1:0];
  endfunction

endpackage

@@ design/stt_front.sv @@
module stt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  input  logic             end_i,
  output logic             push_o,
  output stt_pkg::bundle_t bundle_o
);
  import stt_pkg::*;

  typedef enum logic [9:0] {
    MODE_IDLE    = 10'b0000000001,
    MODE_IDENT   = 10'b0000000010,
    MODE_NUM     = 10'b0000000100,
    MODE_NUMDOT  = 10'b0000001000,
    MODE_FRAC    = 10'b0000010000,
    MODE_STR     = 10'b0000100000,
    MODE_COMMENT = 10'b0001000000,
    MODE_COLON   = 10'b0010000000,
    MODE_EQ      = 10'b0100000000,
    MODE_MINUS   = 10'b1000000000
  } mode_e;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  localparam logic [POSITION_BITS:0] LEN_ZERO = '0;
  localparam logic [POSITION_BITS:0] LEN_ONE  = (POSITION_BITS+1)'(1);
  localparam logic [POSITION_BITS:0] LEN_TWO  = (POSITION_BITS+1)'(2);

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [LINE_BITS-1:0]     line_q;
  logic                     line_inc;
  logic                     rescan;

  logic                     eos, is_alpha, is_dig;
  logic [POSITION_BITS-1:0] len_ps, pos_m1, len_nd;
  logic [POSITION_BITS:0]   len_str;
  token_t [SLOTS-1:0]       tok;
  logic   [SLOTS-1:0]       vld;

  function automatic token_t mk(input tok_kind_e k, input logic [POSITION_BITS-1:0] s,
                                input logic [POSITION_BITS:0] l, input err_e e,
                                input logic [LINE_BITS-1:0] ln);
    token_t t;
    t.kind  = k;
    t.start = sat_pos({1'b0, s});
    t.len   = sat_pos(l);
    t.line  = sat_line(ln);
    t.err   = e;
    return t;
  endfunction

  assign eos      = end_i || (byte_i == CH_NUL);
  assign is_alpha = (byte_i >= 8'h61 && byte_i <= 8'h7A) ||
                    (byte_i >= 8'h41 && byte_i <= 8'h5A) || (byte_i == CH_UNDER);
  assign is_dig   = (byte_i >= 8'h30 && byte_i <= 8'h39);

  assign len_ps  = (pos_q > start_q) ? pos_q - start_q : '0;
  assign pos_m1  = (pos_q != '0) ? pos_q - 1'b1 : '0;
  assign len_nd  = (pos_m1 > start_q) ? pos_m1 - start_q : '0;
  assign len_str = {1'b0, len_ps} + LEN_ONE;

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    line_inc = 1'b0;
    rescan   = 1'b0;
    tok      = '0;
    vld      = '0;
    case (mode_q)
      MODE_IDENT: begin
        if (eos || !(is_alpha || is_dig)) begin
          tok[0] = mk(K_IDENT, start_q, {1'b0, len_ps}, E_NONE, line_q);
          vld[0] = 1'b1;
          rescan = 1'b1;
        end
      end
      MODE_NUM: begin
        if (!eos && byte_i == CH_DOT) begin
          mode_d = MODE_NUMDOT;
        end else if (eos || !is_dig) begin
          tok[0] = mk(K_NUMBER, start_q, {1'b0, len_ps}, E_NONE, line_q);
          vld[0] = 1'b1;
          rescan = 1'b1;
        end
      end
      MODE_NUMDOT: begin
        if (!eos && is_dig) begin
          mode_d = MODE_FRAC;
        end else begin
          tok[0] = mk(K_NUMBER, start_q, {1'b0, len_nd}, E_NONE, line_q);
          tok[1] = mk(K_DOT, pos_m1, LEN_ONE, E_NONE, line_q);
          vld[1:0] = 2'b11;
          rescan = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (eos || !is_dig) begin
          tok[0] = mk(K_NUMBER, start_q, {1'b0, len_ps}, E_NONE, line_q);
          vld[0] = 1'b1;
          rescan = 1'b1;
        end
      end
      MODE_STR: begin
        if (eos) begin
          tok[0] = mk(K_ERROR, start_q, {1'b0, len_ps}, E_UNTERM_STR, line_q);
          vld[0] = 1'b1;
          rescan = 1'b1;
        end else if (byte_i == CH_QUOTE) begin
          tok[0] = mk(K_STRING, start_q, len_str, E_NONE, line_q);
          vld[0] = 1'b1;
          mode_d = MODE_IDLE;
        end else if (byte_i == CH_LF) begin
          line_inc = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (eos || byte_i == CH_LF) begin
          tok[0] = mk(K_COMMENT, start_q, {1'b0, len_ps}, E_NONE, line_q);
          vld[0] = 1'b1;
          rescan = 1'b1;
        end
      end
      MODE_COLON: begin
        vld[0] = 1'b1;
        if (!eos && byte_i == CH_EQUALS) begin
          tok[0] = mk(K_COLON_EQUALS, start_q, LEN_TWO, E_NONE, line_q);
          mode_d = MODE_IDLE;
        end else if (!eos && byte_i == CH_COLON) begin
          tok[0] = mk(K_DOUBLE_COLON, start_q, LEN_TWO, E_NONE, line_q);
          mode_d = MODE_IDLE;
        end else begin
          tok[0] = mk(K_COLON, start_q, LEN_ONE, E_NONE, line_q);
          rescan = 1'b1;
        end
      end
      MODE_EQ: begin
        vld[0] = 1'b1;
        if (!eos && byte_i == CH_GT) begin
          tok[0] = mk(K_DOUBLE_ARROW, start_q, LEN_TWO, E_NONE, line_q);
          mode_d = MODE_IDLE;
        end else begin
          tok[0] = mk(K_EQUALS, start_q, LEN_ONE, E_NONE, line_q);
          rescan = 1'b1;
        end
      end
      MODE_MINUS: begin
        vld[0] = 1'b1;
        if (!eos && byte_i == CH_GT) begin
          tok[0] = mk(K_ARROW, start_q, LEN_TWO, E_NONE, line_q);
          mode_d = MODE_IDLE;
        end else begin
          tok[0] = mk(K_ERROR, start_q, LEN_ONE, E_UNEXPECTED, line_q);
          rescan = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase

    if (rescan) begin
      mode_d = MODE_IDLE;
      if (eos) begin
        tok[2] = mk(K_EOF, pos_q, LEN_ZERO, E_NONE, line_q);
        vld[2] = 1'b1;
      end else if (is_alpha) begin
        start_d = pos_q;
        mode_d  = MODE_IDENT;
      end else if (is_dig) begin
        start_d = pos_q;
        mode_d  = MODE_NUM;
      end else begin
        vld[2] = 1'b1;
        tok[2] = mk(K_ERROR, pos_q, LEN_ONE, E_UNEXPECTED, line_q);
        case (byte_i)
          CH_SPACE, CH_CR, CH_TAB: vld[2] = 1'b0;
          CH_LF: begin
            vld[2]   = 1'b0;
            line_inc = 1'b1;
          end
          CH_LPAREN: tok[2].kind = K_LPAREN;
          CH_RPAREN: tok[2].kind = K_RPAREN;
          CH_LBRACE: tok[2].kind = K_LBRACE;
          CH_RBRACE: tok[2].kind = K_RBRACE;
          CH_LBRACK: tok[2].kind = K_LBRACKET;
          CH_RBRACK: tok[2].kind = K_RBRACKET;
          CH_COMMA:  tok[2].kind = K_COMMA;
          CH_DOT:    tok[2].kind = K_DOT;
          CH_COLON, CH_EQUALS, CH_MINUS, CH_QUOTE, CH_HASH: begin
            vld[2]  = 1'b0;
            start_d = pos_q;
            case (byte_i)
              CH_COLON:  mode_d = MODE_COLON;
              CH_EQUALS: mode_d = MODE_EQ;
              CH_MINUS:  mode_d = MODE_MINUS;
              CH_QUOTE:  mode_d = MODE_STR;
              default:   mode_d = MODE_COMMENT;
            endcase
          end
          default: ;
        endcase
        if (vld[2]) begin
          tok[2].err = (tok[2].kind == K_ERROR) ? E_UNEXPECTED : E_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      line_q  <= LINE_BITS'(1);
    end else if (accept_i) begin
      if (eos) begin
        mode_q  <= MODE_IDLE;
        pos_q   <= '0;
        start_q <= '0;
        line_q  <= LINE_BITS'(1);
      end else begin
        mode_q  <= mode_d;
        start_q <= start_d;
        if (pos_q != '1) begin
          pos_q <= pos_q + 1'b1;
        end
        if (line_inc && line_q != '1) begin
          line_q <= line_q + 1'b1;
        end
      end
    end
  end

  assign push_o       = accept_i && (|vld);
  assign bundle_o.vld = vld;
  assign bundle_o.tok = tok;

endmodule

@@ design/stt_queue.sv @@
module stt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  stt_pkg::bundle_t   data_i,
  input  logic               pop_i,
  output stt_pkg::bundle_t   head_o,
  output stt_pkg::q_status_t status_o
);
  import stt_pkg::*;

  bundle_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] nxt(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign status_o.count = cnt_q;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= nxt(wr_q);
      end
      if (do_pop) begin
        rd_q <= nxt(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ design/stt_back.sv @@
module stt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stt_pkg::bundle_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output stt_pkg::token_t  tok_o,
  output logic             last_o
);
  import stt_pkg::*;

  logic [SLOTS-1:0]  sent_q, sent_d;
  logic [SLOTS-1:0]  rem, sel_oh, others;
  logic [SLOT_W-1:0] sel;
  logic              load;
  logic              valid_q;
  token_t            tok_q;
  logic              last_q;

  assign rem = head_i.vld & ~sent_q;

  always_comb begin
    sel    = '0;
    sel_oh = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (rem[i]) begin
        sel    = SLOT_W'(i);
        sel_oh = SLOTS'(1) << i;
      end
    end
  end

  assign others = rem & ~sel_oh;
  assign load   = !empty_i && (!valid_q || ready_i);
  assign pop_o  = load && (others == '0);
  assign sent_d = pop_o ? '0 : (sent_q | sel_oh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        sent_q  <= sent_d;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= head_i.tok[sel];
      last_q <= (others == '0);
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;
  assign last_o  = last_q;

endmodule

@@ design/source_text_tokenizer_top.sv @@
// A byte's tokens pass through the token queue and then the output register.
// Throughput: one byte per cycle unless the queue is full; one token beat per cycle
// while m_axis_tready is high; a byte closing two or three tokens gives as many beats.
// A four-entry queue of per-byte token groups lets input and output stall apart.
// Reset (rst_ni low, asynchronous): scan idle, position 0, line 1, queue empty.
`include "assert_macros.svh"

module source_text_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value
  input  logic        s_axis_tlast,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // token_kind, start_offset, token_length,
                                      // line_number, error_code, zero pad
  output logic        m_axis_tlast    // last_of_run
);
  import stt_pkg::*;

  logic      accept, push, pop;
  bundle_t   bundle, head;
  q_status_t q_stat;
  token_t    tok;

  assign s_axis_tready = !q_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  stt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .end_i    (s_axis_tlast),
    .push_o   (push),
    .bundle_o (bundle)
  );

  stt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (bundle),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_stat)
  );

  stt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (q_stat.empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .tok_o   (tok),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, tok};

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push && q_stat.full, "push into full queue")
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, q_stat.count > QCNT_W'(QUEUE_DEPTH), "queue count")
  `ASSERT_IMPLIES(a_eof_last, clk_i, rst_ni, m_axis_tvalid && tok.kind == K_EOF, m_axis_tlast, "eof not last")
  `ASSERT_NEXT(a_end_queued, clk_i, rst_ni, accept && s_axis_tlast, !q_stat.empty, "end not queued")

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 12;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = " ";
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_LPAR  = "(";
  localparam logic [7:0] CH_RPAR  = ")";
  localparam logic [7:0] CH_LBRC  = "{";
  localparam logic [7:0] CH_RBRC  = "}";
  localparam logic [7:0] CH_LBRK  = "[";
  localparam logic [7:0] CH_RBRK  = "]";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_US    = "_";

  typedef enum logic [3:0] {
    SC_IDLE, SC_IDENT, SC_NUM, SC_NUMDOT, SC_FRAC, SC_STR, SC_COMMENT,
    SC_COLON, SC_EQ, SC_MINUS
  } scan_e;

  typedef struct {
    logic [7:0] b;
    logic       eos;
  } text_item_t;

  typedef struct {
    token_t tok;
    logic   last;
  } token_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  source_text_tokenizer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  text_item_t  text_q[$];
  token_beat_t pending_tokens[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_cnt  = 0;

  int unsigned fails       = 0;
  int unsigned bytes_in    = 0;
  int unsigned tokens_out  = 0;
  int unsigned in_stalls   = 0;
  int unsigned idle_cycles = 0;
  int unsigned pushed      = 0;

  // scanner shadow state
  scan_e       mode      = SC_IDLE;
  logic [15:0] pos       = 16'd0;
  logic [15:0] tok_start = 16'd0;
  logic [15:0] line_cnt  = 16'd1;
  token_t      new_tok[3];
  int          new_cnt;

  function automatic bit ident_head(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
  endfunction

  function automatic bit decimal(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [16:0] span(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? {1'b0, a - b} : 17'd0;
  endfunction

  function automatic logic [15:0] clip(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  task automatic bump_line();
    if (line_cnt != 16'hFFFF) line_cnt = line_cnt + 16'd1;
  endtask

  task automatic put_tok(input tok_kind_e k, input logic [15:0] st, input logic [16:0] ln,
                         input err_e e);
    if (new_cnt < 3) begin
      new_tok[new_cnt].kind  = k;
      new_tok[new_cnt].start = st;
      new_tok[new_cnt].len   = clip(ln);
      new_tok[new_cnt].line  = line_cnt;
      new_tok[new_cnt].err   = e;
      new_cnt++;
    end
  endtask

  task automatic scan_fresh(input logic [7:0] c, input bit eos, input logic [15:0] p);
    if (eos) begin
      put_tok(K_EOF, p, 17'd0, E_NONE);
    end else if (ident_head(c)) begin
      tok_start = p;
      mode = SC_IDENT;
    end else if (decimal(c)) begin
      tok_start = p;
      mode = SC_NUM;
    end else begin
      case (c)
        CH_SP, CH_CR, CH_TAB: ;
        CH_NL:    bump_line();
        CH_LPAR:  put_tok(K_LPAREN, p, 17'd1, E_NONE);
        CH_RPAR:  put_tok(K_RPAREN, p, 17'd1, E_NONE);
        CH_LBRC:  put_tok(K_LBRACE, p, 17'd1, E_NONE);
        CH_RBRC:  put_tok(K_RBRACE, p, 17'd1, E_NONE);
        CH_LBRK:  put_tok(K_LBRACKET, p, 17'd1, E_NONE);
        CH_RBRK:  put_tok(K_RBRACKET, p, 17'd1, E_NONE);
        CH_COMMA: put_tok(K_COMMA, p, 17'd1, E_NONE);
        CH_DOT:   put_tok(K_DOT, p, 17'd1, E_NONE);
        CH_COLON: begin tok_start = p; mode = SC_COLON; end
        CH_EQ:    begin tok_start = p; mode = SC_EQ; end
        CH_MINUS: begin tok_start = p; mode = SC_MINUS; end
        CH_QUOTE: begin tok_start = p; mode = SC_STR; end
        CH_HASH:  begin tok_start = p; mode = SC_COMMENT; end
        default:  put_tok(K_ERROR, p, 17'd1, E_UNEXPECTED);
      endcase
    end
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic tl);
    bit          eos;
    bit          rescan;
    logic [15:0] p;
    logic [15:0] s;
    logic [15:0] pm1;
    token_beat_t tb_beat;
    eos = tl || (c == CH_NUL);
    p = pos;
    s = tok_start;
    pm1 = (p != 16'd0) ? p - 16'd1 : 16'd0;
    rescan = 0;
    new_cnt = 0;
    case (mode)
      SC_IDLE: rescan = 1;
      SC_IDENT: begin
        if (eos || !(ident_head(c) || decimal(c))) begin
          put_tok(K_IDENT, s, span(p, s), E_NONE);
          rescan = 1;
        end
      end
      SC_NUM: begin
        if (eos || !decimal(c)) begin
          if (!eos && c == CH_DOT) mode = SC_NUMDOT;
          else begin
            put_tok(K_NUMBER, s, span(p, s), E_NONE);
            rescan = 1;
          end
        end
      end
      SC_NUMDOT: begin
        if (!eos && decimal(c)) mode = SC_FRAC;
        else begin
          put_tok(K_NUMBER, s, span(pm1, s), E_NONE);
          put_tok(K_DOT, pm1, 17'd1, E_NONE);
          rescan = 1;
        end
      end
      SC_FRAC: begin
        if (eos || !decimal(c)) begin
          put_tok(K_NUMBER, s, span(p, s), E_NONE);
          rescan = 1;
        end
      end
      SC_STR: begin
        if (eos) begin
          put_tok(K_ERROR, s, span(p, s), E_UNTERM_STR);
          rescan = 1;
        end else if (c == CH_QUOTE) begin
          put_tok(K_STRING, s, span(p, s) + 17'd1, E_NONE);
          mode = SC_IDLE;
        end else if (c == CH_NL) begin
          bump_line();
        end
      end
      SC_COMMENT: begin
        if (eos || c == CH_NL) begin
          put_tok(K_COMMENT, s, span(p, s), E_NONE);
          rescan = 1;
        end
      end
      SC_COLON: begin
        if (!eos && c == CH_EQ) begin
          put_tok(K_COLON_EQUALS, s, 17'd2, E_NONE);
          mode = SC_IDLE;
        end else if (!eos && c == CH_COLON) begin
          put_tok(K_DOUBLE_COLON, s, 17'd2, E_NONE);
          mode = SC_IDLE;
        end else begin
          put_tok(K_COLON, s, 17'd1, E_NONE);
          rescan = 1;
        end
      end
      SC_EQ: begin
        if (!eos && c == CH_GT) begin
          put_tok(K_DOUBLE_ARROW, s, 17'd2, E_NONE);
          mode = SC_IDLE;
        end else begin
          put_tok(K_EQUALS, s, 17'd1, E_NONE);
          rescan = 1;
        end
      end
      SC_MINUS: begin
        if (!eos && c == CH_GT) begin
          put_tok(K_ARROW, s, 17'd2, E_NONE);
          mode = SC_IDLE;
        end else begin
          put_tok(K_ERROR, s, 17'd1, E_UNEXPECTED);
          rescan = 1;
        end
      end
      default: rescan = 1;
    endcase
    if (rescan) begin
      mode = SC_IDLE;
      scan_fresh(c, eos, p);
    end
    if (eos) begin
      mode = SC_IDLE;
      pos = 16'd0;
      tok_start = 16'd0;
      line_cnt = 16'd1;
    end else if (pos != 16'hFFFF) begin
      pos = pos + 16'd1;
    end
    for (int i = 0; i < new_cnt; i++) begin
      tb_beat.tok  = new_tok[i];
      tb_beat.last = (i == new_cnt - 1);
      pending_tokens.push_back(tb_beat);
    end
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // driver
  text_item_t nxt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'd0;
      s_axis_tlast  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = text_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.b;
        s_axis_tlast  <= nxt.eos;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
      hold_done     <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predicts on input beats, checks output beats
  token_beat_t want;
  bit          in_beat;
  bit          out_beat;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_beat  = s_axis_tvalid && s_axis_tready;
      out_beat = m_axis_tvalid && m_axis_tready;
      if (s_axis_tvalid && !s_axis_tready) in_stalls++;
      if (in_beat) begin
        lex_byte(s_axis_tdata, s_axis_tlast);
        bytes_in++;
      end
      if (out_beat) begin
        tokens_out++;
        if (pending_tokens.size() == 0) begin
          $error("token beat with none expected: kind %0d start %0d",
                 m_axis_tdata[4:0], m_axis_tdata[20:5]);
          fails++;
        end else begin
          want = pending_tokens.pop_front();
          cmp_field("token_kind", 16'(want.tok.kind), 16'(m_axis_tdata[4:0]));
          cmp_field("start_offset", want.tok.start, m_axis_tdata[20:5]);
          cmp_field("token_length", want.tok.len, m_axis_tdata[36:21]);
          cmp_field("line_number", want.tok.line, m_axis_tdata[52:37]);
          cmp_field("error_code", 16'(want.tok.err), 16'(m_axis_tdata[54:53]));
          cmp_field("last_of_run", 16'(want.last), 16'(m_axis_tlast));
        end
      end
      if (in_beat || out_beat) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d tokens outstanding",
                 idle_cycles, pending_tokens.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // stimulus
  task automatic push_byte(input logic [7:0] b, input logic eos);
    text_item_t it;
    it.b = b;
    it.eos = eos;
    text_q.push_back(it);
    pushed++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic push_end();
    if ($urandom_range(1)) push_byte(8'($urandom_range(255)), 1'b1);
    else push_byte(CH_NUL, 1'b0);
  endtask

  function automatic logic [7:0] ident_char(input bit first);
    int r;
    r = $urandom_range(first ? 2 : 3);
    case (r)
      0: return 8'("a" + $urandom_range(25));
      1: return 8'("A" + $urandom_range(25));
      2: return CH_US;
      default: return 8'("0" + $urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] text_char(input bit allow_nl);
    logic [7:0] c;
    if (allow_nl && $urandom_range(7) == 0) return CH_NL;
    c = 8'($urandom_range(32, 126));
    return (c == CH_QUOTE) ? CH_APOS : c;
  endfunction

  task automatic add_token();
    string punct;
    string ops[7];
    string blanks;
    int    n;
    punct  = "(){}[],.";
    blanks = " \t\r\n";
    ops = '{":=", "::", "=>", "->", ":", "=", "-"};
    case ($urandom_range(15))
      0, 1, 2: begin
        push_byte(ident_char(1'b1), 1'b0);
        n = $urandom_range(5);
        repeat (n) push_byte(ident_char(1'b0), 1'b0);
      end
      3, 4: begin
        n = $urandom_range(1, 4);
        repeat (n) push_byte(8'("0" + $urandom_range(9)), 1'b0);
        case ($urandom_range(3))
          0: begin
            push_byte(CH_DOT, 1'b0);
            n = $urandom_range(1, 3);
            repeat (n) push_byte(8'("0" + $urandom_range(9)), 1'b0);
          end
          1: push_byte(CH_DOT, 1'b0);
          default: ;
        endcase
      end
      5: begin
        push_byte(CH_QUOTE, 1'b0);
        n = $urandom_range(6);
        repeat (n) push_byte(text_char(1'b1), 1'b0);
        push_byte(CH_QUOTE, 1'b0);
      end
      6: begin
        push_byte(CH_HASH, 1'b0);
        n = $urandom_range(6);
        repeat (n) push_byte(text_char(1'b0), 1'b0);
        push_byte(CH_NL, 1'b0);
      end
      7, 8:   push_byte(punct[$urandom_range(punct.len() - 1)], 1'b0);
      9, 10:  push_str(ops[$urandom_range(6)]);
      11, 12: push_byte(blanks[$urandom_range(3)], 1'b0);
      13:     push_byte(8'($urandom_range(1, 255)), 1'b0);
      14: begin
        // open string, left to run on
        push_byte(CH_QUOTE, 1'b0);
        n = $urandom_range(3);
        repeat (n) push_byte(text_char(1'b1), 1'b0);
      end
      default: push_byte(CH_SP, 1'b0);
    endcase
    if ($urandom_range(1)) push_byte(CH_SP, 1'b0);
  endtask

  task automatic add_random(input int target);
    int start;
    int n;
    start = pushed;
    while (pushed - start < target) begin
      n = $urandom_range(2, 8);
      repeat (n) add_token();
      push_end();
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (text_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (pending_tokens.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_idle(input int unsigned snd, input int unsigned rcv);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_idle(0, 0);
    push_str("a9 4.5 6.x(){}[],.:=::");
    push_byte(8'hFF, 1'b1);
    push_str(":-=>=->#c\n\"s\nq\"@1.");
    push_byte(CH_NUL, 1'b0);
    push_str("\"ab");
    push_byte(8'h00, 1'b1);
    drain();

    add_random(25);
    drain();
    set_idle(58, 0);
    add_random(25);
    drain();
    set_idle(0, 58);
    add_random(25);
    drain();
    set_idle(37, 37);
    add_random(25);
    drain();

    // long receiver hold-off while input keeps coming
    set_idle(0, 0);
    hold_req = 1'b1;
    add_random(30);
    while (!hold_done) @(negedge clk_i);
    drain();
    hold_req = 1'b0;

    // end of text in the middle of open tokens
    push_str("ab 7 \"x\ny\" #z\n:: -");
    push_byte(8'h5A, 1'b1);
    push_str("q1");
    push_end();
    drain();

    $display("summary: %0d bytes in, %0d tokens checked, %0d input stall cycles",
             bytes_in, tokens_out, in_stalls);
    $display("summary: directed, four idling mixes, long hold-off, flush of open tokens");
    if (fails == 0 && pending_tokens.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
